// File: rtl/rectangle_raster_engine_core_macros.svh
// Assertion macros for the rectangle raster engine.
// Every assertion is clocked on i_clk and disabled while i_rst_n is low.
// Defining SYNTH turns the assertions into empty text.
`ifndef RECTANGLE_RASTER_ENGINE_CORE_MACROS_SVH
`define RECTANGLE_RASTER_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH

// Plain property check.
`define RRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RRE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RRE_ASSERT(lbl, prop, msg)
`define RRE_ASSERT_IMPL(lbl, ante, cons, msg)
`define RRE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/rre_pkg.sv
// Shared types and constants of the rectangle raster engine.
// Used by the register block, the sequencer and the top level.
package rre_pkg;

    localparam int FX_W      = 24;  // input fixed-point width
    localparam int FRAC_W    = 8;   // fraction bits
    localparam int SUM_W     = 26;  // corner plus size minus one, exact
    localparam int EDGE_W    = 18;  // truncated edge coordinate, signed
    localparam int CFG_DIM_W = 10;
    localparam int CHAR_W    = 8;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic signed [SUM_W-1:0] FX_ONE   = SUM_W'(256);
    localparam logic signed [SUM_W-1:0] FX_ROUND = SUM_W'(255);

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_W = CFG_DIM_W'(512);
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_H = CFG_DIM_W'(512);
    localparam logic [CHAR_W-1:0]    RST_BG_CHAR = CHAR_W'(32);

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_FRAME_W = 2'd0;
    localparam logic [1:0] REG_FRAME_H = 2'd1;
    localparam logic [1:0] REG_BG_CHAR = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_EDGE,
        ST_CLIP,
        ST_WALK,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_op                     op;
        logic signed [FX_W-1:0]  pos_x;
        logic signed [FX_W-1:0]  pos_y;
        logic signed [FX_W-1:0]  size_w;
        logic signed [FX_W-1:0]  size_h;
        logic                    filled;
        logic [CHAR_W-1:0]       pixel_char;
    } t_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_value;
        logic              status;
    } t_result;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
        logic [CHAR_W-1:0]    background_char;
    } t_cfg;

    // Fixed point to integer, truncated toward zero.
    function automatic logic signed [EDGE_W-1:0] trunc_fx(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] adj;
        adj = v[SUM_W-1] ? v + FX_ROUND : v;
        return EDGE_W'(adj >>> FRAC_W);
    endfunction

endpackage

// File: rtl/rre_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module rre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rre_cfg.sv
// APB register block: frame width, frame height, background character.
// Depends on rre_pkg.
module rre_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rre_pkg::APB_AW-1:0] paddr,
    input  logic [rre_pkg::APB_DW-1:0] pwdata,
    output logic [rre_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rre_pkg::t_cfg              o_cfg
);
    import rre_pkg::*;

    logic [CFG_DIM_W-1:0] r_fw, n_fw;
    logic [CFG_DIM_W-1:0] r_fh, n_fh;
    logic [CHAR_W-1:0]    r_bg, n_bg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        n_fw = r_fw;
        n_fh = r_fh;
        n_bg = r_bg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_W: n_fw = pwdata[CFG_DIM_W-1:0];
                REG_FRAME_H: n_fh = pwdata[CFG_DIM_W-1:0];
                REG_BG_CHAR: n_bg = pwdata[CHAR_W-1:0];
                default:     ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= RST_FRAME_W;
            r_fh <= RST_FRAME_H;
            r_bg <= RST_BG_CHAR;
        end else begin
            r_fw <= n_fw;
            r_fh <= n_fh;
            r_bg <= n_bg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_W: prdata = APB_DW'(r_fw);
            REG_FRAME_H: prdata = APB_DW'(r_fh);
            REG_BG_CHAR: prdata = APB_DW'(r_bg);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = '{frame_width: r_fw, frame_height: r_fh, background_char: r_bg};

endmodule

// File: rtl/rre_seq.sv
// Command sequencer: edge arithmetic, clipping, and the cell walk that
// drives the frame RAM. Depends on rre_pkg and the assertion macros.
`include "rectangle_raster_engine_core_macros.svh"

module rre_seq #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int ADDR_W     = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  rre_pkg::t_cmd              i_cmd,
    input  rre_pkg::t_cfg              i_cfg,
    output logic                       o_done,
    output rre_pkg::t_result           o_result,
    output logic                       o_mem_en,
    output logic                       o_mem_we,
    output logic [ADDR_W-1:0]          o_mem_addr,
    output logic [rre_pkg::CHAR_W-1:0] o_mem_wdata,
    input  logic [rre_pkg::CHAR_W-1:0] i_mem_rdata
);
    import rre_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);

    t_state r_state, n_state;
    logic   r_done, n_done;

    t_cmd    r_cmd, n_cmd;
    t_result r_res, n_res;

    logic signed [SUM_W-1:0]  r_sx, n_sx, r_sxb, n_sxb, r_sy, n_sy, r_syb, n_syb;
    logic signed [EDGE_W-1:0] r_x0, n_x0, r_x1, n_x1, r_xb, n_xb;
    logic signed [EDGE_W-1:0] r_y0, n_y0, r_y1, n_y1, r_yb, n_yb;
    logic [XW-1:0]            r_x, n_x, r_xs, n_xs, r_xlast, n_xlast;
    logic [YW-1:0]            r_y, n_y, r_ylast, n_ylast;
    logic [ADDR_W-1:0]        r_row, n_row;
    logic                     r_fill, n_fill;
    logic [CHAR_W-1:0]        r_char, n_char;

    logic [XW-1:0]            act_w;
    logic [YW-1:0]            act_h;
    logic signed [EDGE_W-1:0] aw_e, ah_e;
    logic signed [EDGE_W-1:0] xs_c, xe_c, ys_c, ye_c;
    logic signed [EDGE_W-1:0] xs_sel, xe_sel, ys_sel, ye_sel;
    logic signed [EDGE_W-1:0] xl_sel, yl_sel;
    logic signed [EDGE_W-1:0] x_e, y_e;
    logic                     empty, oob, border;

    // Effective frame size: saturate the registers to the storage size
    assign act_w = (int'(i_cfg.frame_width) > MAX_WIDTH) ? XW'(MAX_WIDTH)
                                                          : XW'(i_cfg.frame_width);
    assign act_h = (int'(i_cfg.frame_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT)
                                                            : YW'(i_cfg.frame_height);
    assign aw_e  = signed'(EDGE_W'(act_w));
    assign ah_e  = signed'(EDGE_W'(act_h));

    // Clip the rectangle to the frame
    assign xs_c = (r_x0 < 0) ? '0 : r_x0;
    assign ys_c = (r_y0 < 0) ? '0 : r_y0;
    assign xe_c = (r_x1 > aw_e) ? aw_e : r_x1;
    assign ye_c = (r_y1 > ah_e) ? ah_e : r_y1;

    always_comb begin
        if (r_cmd.op == OP_CLEAR) begin
            xs_sel = '0;
            ys_sel = '0;
            xe_sel = aw_e;
            ye_sel = ah_e;
        end else if (r_cmd.op == OP_READ) begin
            xs_sel = r_x0;
            ys_sel = r_y0;
            xe_sel = aw_e;
            ye_sel = ah_e;
        end else begin
            xs_sel = xs_c;
            ys_sel = ys_c;
            xe_sel = xe_c;
            ye_sel = ye_c;
        end
    end

    assign xl_sel = xe_sel - EDGE_W'(1);
    assign yl_sel = ye_sel - EDGE_W'(1);
    assign empty  = (xe_sel <= xs_sel) || (ye_sel <= ys_sel);
    assign oob    = (r_x0 < 0) || (r_y0 < 0) || (r_x0 >= aw_e) || (r_y0 >= ah_e);

    // Border test against the unclipped edges
    assign x_e    = signed'(EDGE_W'(r_x));
    assign y_e    = signed'(EDGE_W'(r_y));
    assign border = (x_e == r_x0) || (x_e == r_xb) || (y_e == r_y0) || (y_e == r_yb);

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_sx    = r_sx;
        n_sxb   = r_sxb;
        n_sy    = r_sy;
        n_syb   = r_syb;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_xb    = r_xb;
        n_y0    = r_y0;
        n_y1    = r_y1;
        n_yb    = r_yb;
        n_x     = r_x;
        n_xs    = r_xs;
        n_xlast = r_xlast;
        n_y     = r_y;
        n_ylast = r_ylast;
        n_row   = r_row;
        n_fill  = r_fill;
        n_char  = r_char;

        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_row + ADDR_W'(r_x);
        o_mem_wdata = r_char;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_res   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_sx    = SUM_W'(r_cmd.pos_x) + SUM_W'(r_cmd.size_w);
                n_sxb   = SUM_W'(r_cmd.pos_x) + SUM_W'(r_cmd.size_w) - FX_ONE;
                n_sy    = SUM_W'(r_cmd.pos_y) + SUM_W'(r_cmd.size_h);
                n_syb   = SUM_W'(r_cmd.pos_y) + SUM_W'(r_cmd.size_h) - FX_ONE;
                n_state = ST_EDGE;
            end
            ST_EDGE: begin
                n_x0    = trunc_fx(SUM_W'(r_cmd.pos_x));
                n_y0    = trunc_fx(SUM_W'(r_cmd.pos_y));
                n_x1    = trunc_fx(r_sx);
                n_xb    = trunc_fx(r_sxb);
                n_y1    = trunc_fx(r_sy);
                n_yb    = trunc_fx(r_syb);
                n_state = ST_CLIP;
            end
            ST_CLIP: begin
                n_x     = xs_sel[XW-1:0];
                n_xs    = xs_sel[XW-1:0];
                n_xlast = xl_sel[XW-1:0];
                n_y     = ys_sel[YW-1:0];
                n_ylast = yl_sel[YW-1:0];
                n_row   = ADDR_W'(ys_sel[YW-1:0]) * ADDR_W'(MAX_WIDTH);
                unique case (r_cmd.op)
                    OP_CLEAR, OP_DRAW: begin
                        n_fill = (r_cmd.op == OP_CLEAR) || r_cmd.filled;
                        n_char = (r_cmd.op == OP_CLEAR) ? i_cfg.background_char
                                                        : r_cmd.pixel_char;
                        if (empty) begin
                            n_done  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_WALK;
                        end
                    end
                    OP_READ: begin
                        if (oob) begin
                            n_res.status = 1'b1;
                            n_done       = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_WALK: begin
                o_mem_en = 1'b1;
                o_mem_we = r_fill || border;
                if (r_x == r_xlast) begin
                    n_x = r_xs;
                    if (r_y == r_ylast) begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_y   = r_y + YW'(1);
                        n_row = r_row + ADDR_W'(MAX_WIDTH);
                    end
                end else begin
                    n_x = r_x + XW'(1);
                end
            end
            ST_READ: begin
                o_mem_en = 1'b1;
                n_state  = ST_RESP;
            end
            ST_RESP: begin
                n_res.cell_value = i_mem_rdata;
                n_done           = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_res   <= n_res;
        r_sx    <= n_sx;
        r_sxb   <= n_sxb;
        r_sy    <= n_sy;
        r_syb   <= n_syb;
        r_x0    <= n_x0;
        r_x1    <= n_x1;
        r_xb    <= n_xb;
        r_y0    <= n_y0;
        r_y1    <= n_y1;
        r_yb    <= n_yb;
        r_x     <= n_x;
        r_xs    <= n_xs;
        r_xlast <= n_xlast;
        r_y     <= n_y;
        r_ylast <= n_ylast;
        r_row   <= n_row;
        r_fill  <= n_fill;
        r_char  <= n_char;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    `RRE_ASSERT_NEXT(a_done_one_cycle, r_done, !r_done, "result strobe held past one cycle")
    `RRE_ASSERT_IMPL(a_done_when_idle, r_done, r_state == ST_IDLE, "result strobe while busy")
    `RRE_ASSERT_NEXT(a_accept_starts, i_start && r_state == ST_IDLE, r_state == ST_SUM,
                     "accepted command did not start")
    `RRE_ASSERT_IMPL(a_write_in_walk, o_mem_we, r_state == ST_WALK,
                     "frame write outside the cell walk")
    `RRE_ASSERT_IMPL(a_walk_bounds, r_state == ST_WALK, (r_x <= r_xlast) && (r_y <= r_ylast),
                     "cell walk left its clipped range")

endmodule

// File: rtl/rectangle_raster_engine_core.sv
// Top level of the rectangle raster engine: register block, sequencer and
// frame RAM. Depends on rre_pkg, rre_cfg, rre_seq and rre_ram.
//
// A character framebuffer rasterizer. A command is taken at a clock edge
// where start is high and busy is low; its one result appears on o_result,
// flagged for exactly one cycle by o_done, and cannot be held off, so
// capture it when o_done is high. Commands run one at a time, limited by
// the single port of the frame RAM, which moves one cell per clock:
//   clear: writes the background character to all W*H cells, where W and
//          H are the frame registers saturated to MAX_WIDTH and MAX_HEIGHT.
//   draw:  walks the clipped columns by the clipped rows; an empty or fully
//          off-frame rectangle writes no cell.
//   read:  reads one cell in frame; a position outside the frame sets status.
//   op 3:  no effect.
// busy drops in the same cycle as the strobe, so the next command may be
// issued right then. Cells that no clear or draw ever covered read back as
// undefined; issue a clear after reset. Write the registers (APB, zero wait
// states) only while busy is low.
module rectangle_raster_engine_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  rre_pkg::t_cmd              i_cmd,
    output logic                       o_done,
    output rre_pkg::t_result           o_result,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rre_pkg::APB_AW-1:0] paddr,
    input  logic [rre_pkg::APB_DW-1:0] pwdata,
    output logic [rre_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import rre_pkg::*;

    // Cell (x, y) lives at y*MAX_WIDTH + x
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg              cfg;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;

    // Frame size and background character
    rre_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Decode, clip and walk the cells of each command
    rre_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_cfg       (cfg),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_mem_en    (mem_en),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    // Frame store: one access per cycle, read data registered
    rre_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule
